>>> rtl/cig_pkg.sv
// ----------------------------------------------------------------------------
// cig_pkg: shared types and constants for the cursor inertia glide block
// Field widths, register indexes and reset values, FSM states and the
// status bundle of the bit-serial arithmetic units.
// ----------------------------------------------------------------------------
package cig_pkg;

  // Default axis width handed to the top level
  localparam int unsigned AXIS_BITS_DEF = 16;

  // Fixed port field widths
  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned THR_W     = 15;
  localparam int unsigned LEN_W     = 12;
  localparam int unsigned DIVR_W    = 8;
  localparam int unsigned CFG_W     = 15;
  localparam int unsigned CFG_IDX_W = 2;

  // Register reset values and limits
  localparam logic [THR_W-1:0]  THR_RST  = THR_W'(30);
  localparam logic [LEN_W-1:0]  MIN_RST  = LEN_W'(35);
  localparam logic [DIVR_W-1:0] DIVR_RST = DIVR_W'(10);
  localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(4095);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_MIN_TICKS = 2'd1,
    CFG_DIVISOR   = 2'd2
  } cig_cfg_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LEN_GO,
    ST_LEN,
    ST_MUL_GO,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV,
    ST_DONE
  } cig_state_e;

  // Status of a bit-serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } cig_unit_stat_t;

endpackage

>>> rtl/cig_in_if.sv
// ----------------------------------------------------------------------------
// cig_in_if: report tick channel
// Valid/ready channel carrying the touch flag and the last reported motion.
// ----------------------------------------------------------------------------
interface cig_in_if import cig_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               touched;
  logic [FIELD_W-1:0] last_dx;
  logic [FIELD_W-1:0] last_dy;

  modport source (output valid, output touched, output last_dx, output last_dy,
                  input ready);
  modport sink   (input valid, input touched, input last_dx, input last_dy,
                  output ready);
endinterface

>>> rtl/cig_out_if.sv
// ----------------------------------------------------------------------------
// cig_out_if: glide motion channel
// Valid/ready channel carrying the emitted motion and the gliding flag.
// ----------------------------------------------------------------------------
interface cig_out_if import cig_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] glide_dx;
  logic [FIELD_W-1:0] glide_dy;
  logic               gliding;

  modport source (output valid, output glide_dx, output glide_dy, output gliding,
                  input ready);
  modport sink   (input valid, input glide_dx, input glide_dy, input gliding,
                  output ready);
endinterface

>>> rtl/cursor_inertia_glide_top.sv
// ----------------------------------------------------------------------------
// cursor_inertia_glide_top: inertial cursor glide after finger release
// Sequencer, glide state, configuration registers and output register
// around bit-serial multipliers and dividers.
// ----------------------------------------------------------------------------
// One result item per report tick. Items are taken one at a time; the result
// sits in an output register, so the next tick is accepted while it waits.
// A touched tick goes straight to the result; an untouched tick at or below
// the threshold adds the threshold check. A glide tick runs the bit-serial
// multiply of |v| by the tick count (LEN_W = 12 steps) and the bit-serial
// divide by the glide length (AXIS_BITS + 12 steps), both axes in parallel
// lanes, plus the sequencing states. The first tick of a glide adds the
// threshold check and the length divide (AXIS_BITS steps). Those serial
// units set the rate; the logic between registers stays one add or compare
// wide.
// ----------------------------------------------------------------------------
module cursor_inertia_glide_top import cig_pkg::*; #(
  parameter int unsigned AXIS_BITS = AXIS_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  cig_in_if.sink               in_i,
  cig_out_if.source            out_o
);

  localparam int unsigned PW    = AXIS_BITS + LEN_W;
  localparam int unsigned CNT_W = $clog2(PW + 1);
  localparam int unsigned CW    = (AXIS_BITS > THR_W) ? AXIS_BITS : THR_W;

  cig_state_e st_q, st_d;

  // Configuration registers
  logic [THR_W-1:0]  thr_q;
  logic [LEN_W-1:0]  min_q;
  logic [DIVR_W-1:0] divr_q;

  // Glide state
  logic [LEN_W-1:0]            tick_q;
  logic [LEN_W-1:0]            len_q;
  logic signed [AXIS_BITS-1:0] start_vx_q, start_vy_q;

  // Result and output registers
  logic signed [AXIS_BITS-1:0] res_dx_q, res_dy_q;
  logic                        res_go_q;
  logic [FIELD_W-1:0]          out_dx_q, out_dy_q;
  logic                        out_go_q;
  logic                        out_valid_q, out_valid_d;

  // Sequencer outputs
  logic in_ready, in_fire, out_load;
  logic mul_start, div_x_start, div_y_start;

  // Arithmetic units
  cig_unit_stat_t mul_x_stat, mul_y_stat, div_x_stat, div_y_stat;
  logic [PW-1:0]    prod_x, prod_y, quo_x, quo_y;
  logic [PW-1:0]    div_x_dvd;
  logic [LEN_W-1:0] div_x_dvs;
  logic [CNT_W-1:0] div_x_steps;

  // Combinational datapath
  logic [AXIS_BITS-1:0]        mag_x, mag_y, big;
  logic                        below;
  logic [DIVR_W-1:0]           divr_eff;
  logic [LEN_W-1:0]            min_eff, cand_sat, len_new;
  logic [AXIS_BITS-1:0]        rmag_x, rmag_y;
  logic signed [AXIS_BITS-1:0] res_x, res_y;
  logic [LEN_W:0]              tick_inc;
  logic                        tick_wrap;
  logic [LEN_W-1:0]            tick_nxt;

  assign in_fire = in_i.valid && in_ready;

  // Magnitudes of the latched motion and the threshold check
  assign mag_x = start_vx_q[AXIS_BITS-1] ? AXIS_BITS'(-start_vx_q) : AXIS_BITS'(start_vx_q);
  assign mag_y = start_vy_q[AXIS_BITS-1] ? AXIS_BITS'(-start_vy_q) : AXIS_BITS'(start_vy_q);
  assign big   = (mag_x > mag_y) ? mag_x : mag_y;
  assign below = (CW'(mag_x) <= CW'(thr_q)) && (CW'(mag_y) <= CW'(thr_q));

  // Glide length: speed / divisor, at least the minimum, saturated
  assign divr_eff = (divr_q == '0) ? DIVR_W'(1) : divr_q;
  assign min_eff  = (min_q == '0) ? LEN_W'(1) : min_q;
  assign cand_sat = (|quo_x[PW-1:LEN_W]) ? LEN_MAX : quo_x[LEN_W-1:0];
  assign len_new  = (cand_sat > min_eff) ? cand_sat : min_eff;

  // Emitted motion: sign(v) * (|v| - |v|*count/length)
  assign rmag_x = mag_x - quo_x[AXIS_BITS-1:0];
  assign rmag_y = mag_y - quo_y[AXIS_BITS-1:0];
  assign res_x  = start_vx_q[AXIS_BITS-1] ? AXIS_BITS'(-rmag_x) : rmag_x;
  assign res_y  = start_vy_q[AXIS_BITS-1] ? AXIS_BITS'(-rmag_y) : rmag_y;

  // Count advance with wrap at the glide length
  assign tick_inc  = {1'b0, tick_q} + 1'b1;
  assign tick_wrap = tick_inc >= {1'b0, len_q};
  assign tick_nxt  = tick_wrap ? '0 : tick_inc[LEN_W-1:0];

  // X lane divider serves the length divide as well
  always_comb begin
    if (st_q == ST_LEN_GO) begin
      div_x_dvd   = {big, {LEN_W{1'b0}}};
      div_x_dvs   = LEN_W'(divr_eff);
      div_x_steps = CNT_W'(AXIS_BITS);
    end else begin
      div_x_dvd   = prod_x;
      div_x_dvs   = len_q;
      div_x_steps = CNT_W'(PW);
    end
  end

  cig_mul_serial #(.A_W(AXIS_BITS), .B_W(LEN_W)) u_mul_x (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mag_x), .b_i(tick_q),
    .product_o(prod_x), .stat_o(mul_x_stat)
  );

  cig_mul_serial #(.A_W(AXIS_BITS), .B_W(LEN_W)) u_mul_y (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mag_y), .b_i(tick_q),
    .product_o(prod_y), .stat_o(mul_y_stat)
  );

  cig_div_serial #(.DVD_W(PW), .DVS_W(LEN_W), .CNT_W(CNT_W)) u_div_x (
    .clk_i, .rst_ni, .start_i(div_x_start), .dividend_i(div_x_dvd),
    .divisor_i(div_x_dvs), .steps_i(div_x_steps),
    .quotient_o(quo_x), .stat_o(div_x_stat)
  );

  cig_div_serial #(.DVD_W(PW), .DVS_W(LEN_W), .CNT_W(CNT_W)) u_div_y (
    .clk_i, .rst_ni, .start_i(div_y_start), .dividend_i(prod_y),
    .divisor_i(len_q), .steps_i(CNT_W'(PW)),
    .quotient_o(quo_y), .stat_o(div_y_stat)
  );

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.touched)        st_d = ST_DONE;
          else if (tick_q == '0)   st_d = ST_CHECK;
          else                     st_d = ST_MUL_GO;
        end
      end
      ST_CHECK:  st_d = below ? ST_DONE : ST_LEN_GO;
      ST_LEN_GO: st_d = ST_LEN;
      ST_LEN:    if (div_x_stat.done) st_d = ST_MUL_GO;
      ST_MUL_GO: st_d = ST_MUL;
      ST_MUL:    if (mul_x_stat.done) st_d = ST_DIV_GO;
      ST_DIV_GO: st_d = ST_DIV;
      ST_DIV:    if (div_x_stat.done) st_d = ST_DONE;
      ST_DONE:   if (out_load) st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready    = 1'b0;
    mul_start   = 1'b0;
    div_x_start = 1'b0;
    div_y_start = 1'b0;
    out_load    = 1'b0;
    unique case (st_q)
      ST_IDLE:   in_ready = 1'b1;
      ST_LEN_GO: div_x_start = 1'b1;
      ST_MUL_GO: mul_start = 1'b1;
      ST_DIV_GO: begin
        div_x_start = 1'b1;
        div_y_start = 1'b1;
      end
      ST_DONE:   out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load)          out_valid_d = 1'b1;
    else if (out_o.ready)  out_valid_d = 1'b0;
  end

  // Control, configuration and glide state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
      thr_q       <= THR_RST;
      min_q       <= MIN_RST;
      divr_q      <= DIVR_RST;
      tick_q      <= '0;
      len_q       <= MIN_RST;
      start_vx_q  <= '0;
      start_vy_q  <= '0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_THRESHOLD: thr_q  <= cfg_data_i[THR_W-1:0];
          CFG_MIN_TICKS: min_q  <= cfg_data_i[LEN_W-1:0];
          CFG_DIVISOR:   divr_q <= cfg_data_i[DIVR_W-1:0];
          default: ;
        endcase
      end
      // touch cancels the glide; first untouched tick latches the motion
      if (in_fire && in_i.touched) begin
        tick_q <= '0;
      end else if (in_fire && tick_q == '0) begin
        start_vx_q <= in_i.last_dx[AXIS_BITS-1:0];
        start_vy_q <= in_i.last_dy[AXIS_BITS-1:0];
      end
      if (st_q == ST_LEN && div_x_stat.done) begin
        len_q <= len_new;
      end
      if (st_q == ST_DIV && div_x_stat.done) begin
        tick_q <= tick_nxt;
      end
    end
  end

  // Result and output payload
  always_ff @(posedge clk_i) begin
    if ((in_fire && in_i.touched) || (st_q == ST_CHECK && below)) begin
      res_dx_q <= '0;
      res_dy_q <= '0;
      res_go_q <= 1'b0;
    end else if (st_q == ST_DIV && div_x_stat.done) begin
      res_dx_q <= res_x;
      res_dy_q <= res_y;
      res_go_q <= !tick_wrap;
    end
    if (out_load) begin
      out_dx_q <= FIELD_W'(res_dx_q);
      out_dy_q <= FIELD_W'(res_dy_q);
      out_go_q <= res_go_q;
    end
  end

  assign in_i.ready     = in_ready;
  assign out_o.valid    = out_valid_q;
  assign out_o.glide_dx = out_dx_q;
  assign out_o.glide_dy = out_dy_q;
  assign out_o.gliding  = out_go_q;

  // Count always stays inside the current glide
  a_tick_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_q < len_q)
    else $error("tick count reached glide length");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q != '0)
    else $error("glide length is zero");

  // A continuing glide leaves a nonzero count behind
  a_go_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DONE && res_go_q) |-> (tick_q != '0))
    else $error("gliding flag with cleared count");

  // Both lanes run in lockstep
  a_lanes_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_x_stat.done == mul_y_stat.done) &&
    ((st_q != ST_DIV) || (div_x_stat.done == div_y_stat.done)))
    else $error("axis lanes out of step");

  // Scaled-down part never exceeds the start magnitude
  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DIV && div_y_stat.done) |-> (quo_y <= PW'(mag_y)))
    else $error("glide quotient above start magnitude");

endmodule

>>> rtl/cig_mul_serial.sv
// ----------------------------------------------------------------------------
// cig_mul_serial: bit-serial unsigned multiplier
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module cig_mul_serial import cig_pkg::*; #(
  parameter int unsigned A_W = AXIS_BITS_DEF,
  parameter int unsigned B_W = LEN_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [A_W-1:0]   a_i,
  input  logic [B_W-1:0]   b_i,
  output logic [A_W+B_W-1:0] product_o,
  output cig_unit_stat_t   stat_o
);

  localparam int unsigned P_W   = A_W + B_W;
  localparam int unsigned CNT_W = $clog2(B_W + 1);

  logic [P_W-1:0]   prod_q, prod_d;
  logic [P_W-1:0]   mcand_q, mcand_d;
  logic [B_W-1:0]   mplier_q, mplier_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  // One shift-add step per cycle
  always_comb begin
    prod_d   = prod_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (start_i) begin
      prod_d   = '0;
      mcand_d  = P_W'(a_i);
      mplier_d = b_i;
      cnt_d    = CNT_W'(B_W);
      busy_d   = 1'b1;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        prod_d = prod_q + mcand_q;
      end
      mcand_d  = mcand_q << 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign product_o   = prod_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

>>> rtl/cig_div_serial.sv
// ----------------------------------------------------------------------------
// cig_div_serial: bit-serial restoring divider
// One quotient bit per cycle. The dividend is left-aligned so that a run of
// steps_i steps leaves the quotient in the low steps_i bits.
// ----------------------------------------------------------------------------
module cig_div_serial import cig_pkg::*; #(
  parameter int unsigned DVD_W = AXIS_BITS_DEF + LEN_W,
  parameter int unsigned DVS_W = LEN_W,
  parameter int unsigned CNT_W = $clog2(DVD_W + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  input  logic [CNT_W-1:0] steps_i,
  output logic [DVD_W-1:0] quotient_o,
  output cig_unit_stat_t   stat_o
);

  logic [DVD_W-1:0] acc_q, acc_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  // Trial subtract of the shifted remainder
  assign trial = {rem_q, acc_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    acc_d  = acc_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = steps_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // no borrow: the divisor fits, quotient bit is one
      if (!diff[DVS_W]) begin
        rem_d = diff[DVS_W-1:0];
      end else begin
        rem_d = trial[DVS_W-1:0];
      end
      acc_d = {acc_q[DVD_W-2:0], ~diff[DVS_W]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = acc_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

>>> tb/cursor_inertia_glide_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_inertia_glide_top_tb: self-checking bench for the inertia glide block
// Report ticks are fed through a valid/ready driver. Every accepted tick runs
// through a behavioral glide predictor. A monitor compares each result item
// with the oldest predicted one. Directed ticks cover the touch, threshold,
// saturation and zero-register cases. Random gestures follow under several
// register settings and idle/stall mixes, with one long output hold-off.
// ----------------------------------------------------------------------------
module cursor_inertia_glide_top_tb;
  import cig_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned SETTLE_CYC  = 80;
  localparam int unsigned HOLD_CYC    = 700;
  localparam int unsigned PHASE_TICKS = 425;

  typedef struct packed {
    logic               touched;
    logic [FIELD_W-1:0] last_dx;
    logic [FIELD_W-1:0] last_dy;
  } tick_t;

  typedef struct packed {
    logic [FIELD_W-1:0] glide_dx;
    logic [FIELD_W-1:0] glide_dy;
    logic               gliding;
  } glide_res_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  cig_in_if  tick_if ();
  cig_out_if glide_if ();

  cursor_inertia_glide_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_i        (tick_if),
    .out_o       (glide_if)
  );

  // Pending ticks and predicted results
  tick_t       tick_q[$];
  glide_res_t  glide_exp_q[$];
  tick_t       drv_tick;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;

  // Register mirror
  int thr_val = int'(THR_RST);
  int min_val = int'(MIN_RST);
  int div_val = int'(DIVR_RST);

  // Predictor glide state
  int glide_tick = 0;
  int glide_len  = int'(MIN_RST);
  int start_vx   = 0;
  int start_vy   = 0;

  // Clock, and every input at a known level from time zero
  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_THRESHOLD;
    cfg_data         = '0;
    tick_if.valid    = 1'b0;
    tick_if.touched  = 1'b0;
    tick_if.last_dx  = '0;
    tick_if.last_dy  = '0;
    glide_if.ready   = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Behavioral glide step: one tick in, one result out
  function automatic glide_res_t glide_step(logic touched, logic [FIELD_W-1:0] dx,
                                            logic [FIELD_W-1:0] dy);
    glide_res_t res;
    int ax, ay, top, dvs, mn, ln, c, ox, oy;
    bit run;
    res = '0;
    ox  = 0;
    oy  = 0;
    if (touched) begin
      glide_tick = 0;
    end else begin
      run = 1'b1;
      // first untouched tick latches the motion and sizes the glide
      if (glide_tick == 0) begin
        start_vx = int'($signed(dx));
        start_vy = int'($signed(dy));
        ax = (start_vx < 0) ? -start_vx : start_vx;
        ay = (start_vy < 0) ? -start_vy : start_vy;
        if (ax <= thr_val && ay <= thr_val) begin
          run = 1'b0;
        end else begin
          top = (ax > ay) ? ax : ay;
          dvs = (div_val != 0) ? div_val : 1;
          mn  = (min_val != 0) ? min_val : 1;
          ln  = top / dvs;
          if (ln < mn) ln = mn;
          if (ln > int'(LEN_MAX)) ln = int'(LEN_MAX);
          glide_len = ln;
        end
      end
      // linear decay, truncated toward zero
      if (run) begin
        ln = (glide_len != 0) ? glide_len : 1;
        c  = (glide_tick < ln) ? glide_tick : 0;
        ox = start_vx - (start_vx * c) / ln;
        oy = start_vy - (start_vy * c) / ln;
        c++;
        if (c >= ln) c = 0;
        glide_tick  = c;
        res.gliding = (c != 0);
      end
    end
    res.glide_dx = FIELD_W'(ox);
    res.glide_dy = FIELD_W'(oy);
    return res;
  endfunction

  // Tick driver: predicts on acceptance, then offers the next pending tick
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (tick_if.valid && tick_if.ready) begin
        glide_exp_q.push_back(glide_step(tick_if.touched, tick_if.last_dx,
                                         tick_if.last_dy));
      end
      if (!tick_if.valid || tick_if.ready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_tick         = tick_q.pop_front();
          tick_if.valid   <= 1'b1;
          tick_if.touched <= drv_tick.touched;
          tick_if.last_dx <= drv_tick.last_dx;
          tick_if.last_dy <= drv_tick.last_dy;
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  // Output hold-off counter
  always @(posedge clk_i) begin
    if (hold_cycles != 0) hold_cycles <= hold_cycles - 1;
  end

  // Result monitor and ready generator
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (glide_if.valid && glide_if.ready) begin
        if (glide_exp_q.size() == 0) begin
          $error("unexpected result item: glide_dx %0d glide_dy %0d gliding %0b",
                 $signed(glide_if.glide_dx), $signed(glide_if.glide_dy),
                 glide_if.gliding);
          err_cnt++;
        end else begin
          check_result(glide_exp_q.pop_front());
        end
      end
      glide_if.ready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_result(glide_res_t exp_res);
    if (glide_if.glide_dx !== exp_res.glide_dx) begin
      $error("glide_dx mismatch: expected %0d, actual %0d",
             $signed(exp_res.glide_dx), $signed(glide_if.glide_dx));
      err_cnt++;
    end
    if (glide_if.glide_dy !== exp_res.glide_dy) begin
      $error("glide_dy mismatch: expected %0d, actual %0d",
             $signed(exp_res.glide_dy), $signed(glide_if.glide_dy));
      err_cnt++;
    end
    if (glide_if.gliding !== exp_res.gliding) begin
      $error("gliding mismatch: expected %0b, actual %0b",
             exp_res.gliding, glide_if.gliding);
      err_cnt++;
    end
  endtask

  // Run-length guard
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_tick(bit touched, int dx, int dy);
    tick_t tk;
    tk.touched = touched;
    tk.last_dx = FIELD_W'(dx);
    tk.last_dy = FIELD_W'(dy);
    tick_q.push_back(tk);
  endtask

  // Axis value in +/-32767, mostly moderate speeds
  function automatic int rand_axis(bit wide);
    int mag;
    mag = (wide || $urandom_range(7) == 0) ? $urandom_range(32767) : $urandom_range(2500);
    return $urandom_range(1) ? -mag : mag;
  endfunction

  // Gestures: a few touched ticks, a release, then untouched ticks; some noise
  task automatic queue_gestures(int unsigned n_ticks);
    int unsigned added;
    int unsigned n_touch, n_free;
    added = 0;
    while (added < n_ticks) begin
      if ($urandom_range(9) == 0) begin
        push_tick($urandom_range(1), rand_axis(1'b1), rand_axis(1'b1));
        added++;
      end else begin
        n_touch = $urandom_range(3);
        n_free  = $urandom_range(1, 30);
        repeat (n_touch) push_tick(1'b1, rand_axis(1'b1), rand_axis(1'b1));
        push_tick(1'b0, rand_axis(1'b0), rand_axis(1'b0));
        repeat (n_free - 1) push_tick(1'b0, rand_axis(1'b0), rand_axis(1'b0));
        added += n_touch + n_free;
      end
    end
  endtask

  // Wait until every tick is taken and every result has come back
  task automatic drain();
    do @(negedge clk_i);
    while (tick_q.size() != 0 || tick_if.valid || glide_exp_q.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Write all three registers back to back; block must be idle
  task automatic set_regs(int unsigned thr, int unsigned mn, int unsigned dv);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_THRESHOLD;
    cfg_data  <= CFG_W'(thr);
    thr_val    = int'(thr & ((1 << THR_W) - 1));
    @(posedge clk_i);
    cfg_index <= CFG_MIN_TICKS;
    cfg_data  <= CFG_W'(mn);
    min_val    = int'(mn & ((1 << LEN_W) - 1));
    @(posedge clk_i);
    cfg_index <= CFG_DIVISOR;
    cfg_data  <= CFG_W'(dv);
    div_val    = int'(dv & ((1 << DIVR_W) - 1));
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: touch at full scale, threshold edge, glide start, cancel
    push_tick(1'b1, 32767, -32767);
    push_tick(1'b0, 30, -30);
    push_tick(1'b0, -31, 5);
    push_tick(1'b0, 'h1234, -1);
    push_tick(1'b1, 0, 0);
    push_tick(1'b0, 32767, -32767);
    push_tick(1'b1, -32767, 32767);
    drain();

    // Zero threshold: two-tick glide ends, zero motion stays idle, length saturates
    set_regs(0, 2, 1);
    push_tick(1'b0, 1, 0);
    push_tick(1'b0, 0, 0);
    push_tick(1'b0, 0, 0);
    push_tick(1'b0, -5, 3);
    repeat (4) push_tick(1'b0, 0, 0);
    push_tick(1'b0, 32767, -32767);
    push_tick(1'b0, 0, 0);
    push_tick(1'b1, 0, 0);
    drain();

    // Top threshold with all-ones writes: nothing glides
    set_regs('h7FFF, 'h7FFF, 'h7FFF);
    push_tick(1'b0, 32767, -32767);
    push_tick(1'b1, 0, 0);
    drain();

    // Zero minimum length reads as one
    set_regs(0, 0, 255);
    push_tick(1'b0, 3, -2);
    push_tick(1'b0, -21846, 21845);
    push_tick(1'b1, 0, 0);
    drain();

    // Zero divisor reads as one
    set_regs(5, 3, 0);
    push_tick(1'b0, -7, 6);
    push_tick(1'b0, 0, 0);
    push_tick(1'b1, 0, 0);
    drain();

    // Random gestures, no idling
    set_regs(30, 4, 200);
    queue_gestures(PHASE_TICKS);
    drain();

    // Sender mostly idle
    set_regs(0, 1, 255);
    set_idling(83, 0);
    queue_gestures(PHASE_TICKS);
    drain();

    // Receiver mostly stalling, with one long hold-off while ticks keep coming
    set_regs(1000, 12, 128);
    set_idling(0, 83);
    queue_gestures(PHASE_TICKS);
    @(posedge clk_i);
    hold_cycles <= HOLD_CYC;
    drain();

    // Both sides idling lightly, random settings
    set_regs($urandom_range(300), $urandom_range(1, 16), $urandom_range(100, 255));
    set_idling(19, 19);
    queue_gestures(PHASE_TICKS);
    drain();

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
